### design/prlp_pkg.sv
package prlp_pkg;

  localparam int MaxPathUnits = 32767;
  localparam int QueueDepth   = 4;
  localparam int RootLenW     = 15;
  localparam int MaxRootLen   = 32767;

  localparam logic [7:0] ChSep   = 8'h5C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChClose = 8'h7D;
  localparam logic [7:0] ChU     = 8'h55;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChO     = 8'h4F;

  localparam logic [2:0] LastGuidGroup = 3'd4;
  localparam logic [2:0] GuidGroups    = 3'd5;
  localparam logic [3:0] VolWordLen    = 4'd7;

  // One code unit after classification.
  typedef struct packed {
    logic       term;
    logic       ascii;
    logic [7:0] upper;
    logic       letter;
    logic       hex;
  } unit_class_t;

  typedef enum logic [21:0] {
    PH_START   = 22'h000001,
    PH_S1      = 22'h000002,
    PH_DRV1    = 22'h000004,
    PH_DRV2    = 22'h000008,
    PH_S2      = 22'h000010,
    PH_SERVER  = 22'h000020,
    PH_SHARE   = 22'h000040,
    PH_Q3      = 22'h000080,
    PH_X4      = 22'h000100,
    PH_D5      = 22'h000200,
    PH_D6      = 22'h000400,
    PH_U5      = 22'h000800,
    PH_U6      = 22'h001000,
    PH_U7      = 22'h002000,
    PH_V5      = 22'h004000,
    PH_VPREFIX = 22'h008000,
    PH_HEX     = 22'h010000,
    PH_DASH    = 22'h020000,
    PH_CLOSE   = 22'h040000,
    PH_VEND    = 22'h080000,
    PH_DONE    = 22'h100000,
    PH_BAD     = 22'h200000
  } phase_t;

  function automatic logic [7:0] volume_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h56;
      4'd1:    ch = 8'h4F;
      4'd2:    ch = 8'h4C;
      4'd3:    ch = 8'h55;
      4'd4:    ch = 8'h4D;
      4'd5:    ch = 8'h45;
      4'd6:    ch = 8'h7B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] group_len(input logic [2:0] grp);
    logic [3:0] len;
    case (grp)
      3'd0:    len = 4'd8;
      3'd1:    len = 4'd4;
      3'd2:    len = 4'd4;
      3'd3:    len = 4'd4;
      3'd4:    len = 4'd12;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

### design/prlp_front.sv
module prlp_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            in_code_unit,
  input  logic                   q_full,
  output logic                   push,
  output prlp_pkg::unit_class_t  push_word
);

  logic       hi_zero;
  logic [7:0] lo;
  logic       is_lower;
  logic [7:0] upper;

  assign hi_zero  = (in_code_unit[15:8] == 8'h00);
  assign lo       = in_code_unit[7:0];
  assign is_lower = hi_zero && (lo >= 8'h61) && (lo <= 8'h7A);
  assign upper    = is_lower ? (lo - 8'd32) : lo;

  assign push_word.term   = (in_code_unit == 16'h0000);
  assign push_word.ascii  = hi_zero;
  assign push_word.upper  = upper;
  assign push_word.letter = hi_zero && (upper >= 8'h41) && (upper <= 8'h5A);
  assign push_word.hex    = hi_zero && (((lo >= 8'h30) && (lo <= 8'h39)) ||
                                        ((upper >= 8'h41) && (upper <= 8'h46)));

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

### design/prlp_queue.sv
module prlp_queue #(
  parameter int DEPTH = prlp_pkg::QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  prlp_pkg::unit_class_t  push_word,
  output logic                   full,
  input  logic                   pop,
  output logic                   q_valid,
  output prlp_pkg::unit_class_t  q_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  prlp_pkg::unit_class_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_fill_to_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && (count_r == CNT_W'(DEPTH - 1)) |=> full)
    else $error("queue did not report full");

endmodule

### design/prlp_back.sv
module prlp_back #(
  parameter int MAX_PATH_UNITS = prlp_pkg::MaxPathUnits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  prlp_pkg::unit_class_t         q_word,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prlp_pkg::RootLenW-1:0] out_root_length,
  output logic                          out_invalid
);

  localparam int POS_W = $clog2(MAX_PATH_UNITS + 1);
  localparam int LEN_W = (POS_W > 6) ? POS_W : 6;

  prlp_pkg::phase_t phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] root_end_r, root_end_nxt;
  logic             decided_r, decided_nxt;
  logic             share_empty_r, share_empty_nxt;
  logic [2:0]       guid_seg_r, guid_seg_nxt;
  logic [3:0]       seg_cnt_r, seg_cnt_nxt;
  logic [3:0]       seg_inc;
  logic             overflow_r, overflow_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [prlp_pkg::RootLenW-1:0] out_len_r;
  logic                          out_inv_r;

  logic             out_free;
  logic             load;
  logic             sep, colon, quest, dash, close_br;
  logic             is_u, is_v, is_n, is_c, is_o;
  logic [LEN_W-1:0] pos_len;
  logic [LEN_W-1:0] r_val;
  logic             r_ok;
  logic [31:0]      r_wide;
  logic             res_invalid;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = q_valid && (!q_word.term || out_free);
  assign load     = pop && q_word.term;

  assign sep      = q_word.ascii && (q_word.upper == prlp_pkg::ChSep);
  assign colon    = q_word.ascii && (q_word.upper == prlp_pkg::ChColon);
  assign quest    = q_word.ascii && (q_word.upper == prlp_pkg::ChQuest);
  assign dash     = q_word.ascii && (q_word.upper == prlp_pkg::ChDash);
  assign close_br = q_word.ascii && (q_word.upper == prlp_pkg::ChClose);
  assign is_u     = q_word.ascii && (q_word.upper == prlp_pkg::ChU);
  assign is_v     = q_word.ascii && (q_word.upper == prlp_pkg::ChV);
  assign is_n     = q_word.ascii && (q_word.upper == prlp_pkg::ChN);
  assign is_c     = q_word.ascii && (q_word.upper == prlp_pkg::ChC);
  assign is_o     = q_word.ascii && (q_word.upper == prlp_pkg::ChO);

  assign pos_len = LEN_W'(pos_r);
  assign seg_inc = seg_cnt_r + 4'd1;

  always_comb begin
    r_ok  = 1'b1;
    r_val = '0;
    unique case (phase_r)
      prlp_pkg::PH_S1:     r_val = LEN_W'(1);
      prlp_pkg::PH_DRV2:   r_val = LEN_W'(2);
      prlp_pkg::PH_S2:     r_val = LEN_W'(2);
      prlp_pkg::PH_SERVER: r_val = pos_len;
      prlp_pkg::PH_SHARE:  r_val = pos_len;
      prlp_pkg::PH_D6:     r_val = LEN_W'(6);
      prlp_pkg::PH_VEND:   r_val = LEN_W'(48);
      prlp_pkg::PH_DONE:   r_val = root_end_r;
      default:             r_ok  = 1'b0;
    endcase
  end

  assign r_wide      = 32'(r_val);
  assign res_invalid = overflow_r || !r_ok || (r_wide > 32'(prlp_pkg::MaxRootLen));

  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    root_end_nxt    = root_end_r;
    decided_nxt     = decided_r;
    share_empty_nxt = share_empty_r;
    guid_seg_nxt    = guid_seg_r;
    seg_cnt_nxt     = seg_cnt_r;
    overflow_nxt    = overflow_r;
    if (pop) begin
      if (q_word.term) begin
        phase_nxt       = prlp_pkg::PH_START;
        pos_nxt         = '0;
        root_end_nxt    = '0;
        decided_nxt     = 1'b0;
        share_empty_nxt = 1'b1;
        guid_seg_nxt    = '0;
        seg_cnt_nxt     = '0;
        overflow_nxt    = 1'b0;
      end else begin
        unique case (phase_r)
          prlp_pkg::PH_START: begin
            if (sep) begin
              phase_nxt = prlp_pkg::PH_S1;
            end else if (q_word.letter) begin
              phase_nxt = prlp_pkg::PH_DRV1;
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_S1: begin
            if (sep) begin
              phase_nxt = prlp_pkg::PH_S2;
            end else begin
              phase_nxt    = prlp_pkg::PH_DONE;
              root_end_nxt = LEN_W'(1);
            end
          end
          prlp_pkg::PH_DRV1: begin
            phase_nxt = colon ? prlp_pkg::PH_DRV2 : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_DRV2: begin
            phase_nxt    = prlp_pkg::PH_DONE;
            root_end_nxt = sep ? LEN_W'(3) : LEN_W'(2);
          end
          prlp_pkg::PH_S2: begin
            if (quest) begin
              phase_nxt = prlp_pkg::PH_Q3;
            end else if (sep) begin
              phase_nxt       = prlp_pkg::PH_SHARE;
              share_empty_nxt = 1'b1;
            end else begin
              phase_nxt = prlp_pkg::PH_SERVER;
            end
          end
          prlp_pkg::PH_SERVER: begin
            if (sep) begin
              phase_nxt       = prlp_pkg::PH_SHARE;
              share_empty_nxt = 1'b1;
            end
          end
          prlp_pkg::PH_SHARE: begin
            if (share_empty_r) begin
              if (sep) begin
                phase_nxt    = prlp_pkg::PH_DONE;
                root_end_nxt = pos_len;
              end else begin
                share_empty_nxt = 1'b0;
              end
            end else if (sep) begin
              phase_nxt    = prlp_pkg::PH_DONE;
              root_end_nxt = pos_len + 1'b1;
            end
          end
          prlp_pkg::PH_Q3: begin
            phase_nxt = sep ? prlp_pkg::PH_X4 : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_X4: begin
            if (is_u) begin
              phase_nxt = prlp_pkg::PH_U5;
            end else if (is_v) begin
              phase_nxt = prlp_pkg::PH_V5;
            end else if (q_word.letter) begin
              phase_nxt = prlp_pkg::PH_D5;
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_D5: begin
            phase_nxt = colon ? prlp_pkg::PH_D6 : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_D6: begin
            phase_nxt    = prlp_pkg::PH_DONE;
            root_end_nxt = sep ? LEN_W'(7) : LEN_W'(6);
          end
          prlp_pkg::PH_U5: begin
            if (colon) begin
              phase_nxt = prlp_pkg::PH_D6;
            end else if (is_n) begin
              phase_nxt = prlp_pkg::PH_U6;
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_U6: begin
            phase_nxt = is_c ? prlp_pkg::PH_U7 : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_U7: begin
            phase_nxt = sep ? prlp_pkg::PH_SERVER : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_V5: begin
            if (colon) begin
              phase_nxt = prlp_pkg::PH_D6;
            end else if (is_o) begin
              seg_cnt_nxt = 4'd2;
              phase_nxt   = prlp_pkg::PH_VPREFIX;
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_VPREFIX: begin
            if ((seg_cnt_r < prlp_pkg::VolWordLen) && q_word.ascii &&
                (q_word.upper == prlp_pkg::volume_char(seg_cnt_r))) begin
              if (seg_inc == prlp_pkg::VolWordLen) begin
                seg_cnt_nxt  = '0;
                guid_seg_nxt = '0;
                phase_nxt    = prlp_pkg::PH_HEX;
              end else begin
                seg_cnt_nxt = seg_inc;
              end
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_HEX: begin
            if (q_word.hex && (guid_seg_r < prlp_pkg::GuidGroups)) begin
              seg_cnt_nxt = seg_inc;
              if (seg_inc >= prlp_pkg::group_len(guid_seg_r)) begin
                phase_nxt = (guid_seg_r < prlp_pkg::LastGuidGroup) ?
                            prlp_pkg::PH_DASH : prlp_pkg::PH_CLOSE;
              end
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_DASH: begin
            if (dash) begin
              guid_seg_nxt = guid_seg_r + 3'd1;
              seg_cnt_nxt  = '0;
              phase_nxt    = prlp_pkg::PH_HEX;
            end else begin
              phase_nxt = prlp_pkg::PH_BAD;
            end
          end
          prlp_pkg::PH_CLOSE: begin
            phase_nxt = close_br ? prlp_pkg::PH_VEND : prlp_pkg::PH_BAD;
          end
          prlp_pkg::PH_VEND: begin
            phase_nxt    = prlp_pkg::PH_DONE;
            root_end_nxt = sep ? LEN_W'(49) : LEN_W'(48);
          end
          prlp_pkg::PH_DONE: begin
            phase_nxt = prlp_pkg::PH_DONE;
          end
          default: begin
            phase_nxt    = prlp_pkg::PH_BAD;
            root_end_nxt = '0;
          end
        endcase
        if ((phase_nxt == prlp_pkg::PH_DONE) || (phase_nxt == prlp_pkg::PH_BAD)) begin
          decided_nxt = 1'b1;
        end
        if (phase_nxt == prlp_pkg::PH_BAD) begin
          root_end_nxt = '0;
        end
        if (pos_r >= POS_W'(MAX_PATH_UNITS)) begin
          overflow_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= prlp_pkg::PH_START;
      pos_r         <= '0;
      root_end_r    <= '0;
      decided_r     <= 1'b0;
      share_empty_r <= 1'b1;
      guid_seg_r    <= '0;
      seg_cnt_r     <= '0;
      overflow_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      root_end_r    <= root_end_nxt;
      decided_r     <= decided_nxt;
      share_empty_r <= share_empty_nxt;
      guid_seg_r    <= guid_seg_nxt;
      seg_cnt_r     <= seg_cnt_nxt;
      overflow_r    <= overflow_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_inv_r <= res_invalid;
      out_len_r <= res_invalid ? '0 : r_wide[prlp_pkg::RootLenW-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_length = out_len_r;
  assign out_invalid     = out_inv_r;

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (phase_r == prlp_pkg::PH_START) && (pos_r == '0) && !decided_r)
    else $error("parser did not restart after a terminator");

  a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> (pos_r == POS_W'(MAX_PATH_UNITS)))
    else $error("overflow flag set below the path limit");

  a_decided: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == prlp_pkg::PH_DONE) || (phase_r == prlp_pkg::PH_BAD)) |-> decided_r)
    else $error("final phase without a decided root");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inv_r |-> (out_len_r == '0))
    else $error("invalid result carries a nonzero length");

endmodule

### design/path_root_length_parser.sv
// Streams a path in one 16-bit code unit per word and, on the terminating zero word, returns
// one word with the root prefix length or the invalid flag. A word is accepted every cycle
// while the input queue has room; the parser state machine consumes one queued code unit per
// cycle while it is not stalled, so the sustained rate is one code unit per clock. A result
// passes through a queue slot and then the output register before it becomes valid, and the
// parser stalls only when a terminator meets an output register that still holds an untaken
// result.
module path_root_length_parser #(
  parameter int MAX_PATH_UNITS = prlp_pkg::MaxPathUnits,
  parameter int QUEUE_DEPTH    = prlp_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_code_unit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prlp_pkg::RootLenW-1:0] out_root_length,
  output logic                          out_invalid
);

  logic                  q_full;
  logic                  push;
  prlp_pkg::unit_class_t push_word;
  logic                  pop;
  logic                  q_valid;
  prlp_pkg::unit_class_t q_word;

  prlp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .q_full       (q_full),
    .push         (push),
    .push_word    (push_word)
  );

  prlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  prlp_back #(
    .MAX_PATH_UNITS (MAX_PATH_UNITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_root_length (out_root_length),
    .out_invalid     (out_invalid)
  );

endmodule

### sim/path_root_length_parser_tb.sv
`timescale 1ns / 100ps

module path_root_length_parser_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_UNITS   = 1200;
  localparam int CALM_UNITS     = 1000;
  localparam int MIN_RND_PATHS  = 60;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [15:0] U_TERM  = 16'h0000;
  localparam logic [15:0] U_SEP   = 16'h005C;
  localparam logic [15:0] U_COLON = 16'h003A;
  localparam logic [15:0] U_QUEST = 16'h003F;
  localparam logic [15:0] U_DASH  = 16'h002D;
  localparam logic [15:0] U_OPEN  = 16'h007B;
  localparam logic [15:0] U_CLOSE = 16'h007D;
  localparam logic [15:0] U_PAD   = 16'h0061;

  localparam logic [55:0] VOL_WORD       = "VOLUME{";
  localparam logic [19:0] GUID_GROUP_LEN = {4'd8, 4'd4, 4'd4, 4'd4, 4'd12};

  typedef struct packed {
    logic [14:0] len;
    logic        inv;
  } root_result_t;

  typedef struct {
    string head;
    int    pad;
    bit    typed;
    int    want_len;
    bit    want_inv;
  } path_case_t;

  // In the heads, '#' stands for 0xFFFF, '$' for 0x0141 and '%' for 0x015C.
  path_case_t dir_cases [25] = '{
    '{"", 0, 1'b1, 0, 1'b1},
    '{"\\", 0, 1'b1, 1, 1'b0},
    '{"\\a\\b", 0, 1'b1, 1, 1'b0},
    '{"C:", 0, 1'b1, 2, 1'b0},
    '{"z:\\dir", 0, 1'b1, 3, 1'b0},
    '{"Q:x", 0, 1'b1, 2, 1'b0},
    '{"1:\\", 0, 1'b1, 0, 1'b1},
    '{"$:\\", 0, 1'b1, 0, 1'b1},
    '{"#", 0, 1'b1, 0, 1'b1},
    '{"\\\\", 0, 1'b1, 2, 1'b0},
    '{"\\\\srv\\share\\rest", 0, 1'b0, 0, 1'b0},
    '{"\\\\srv", 0, 1'b0, 0, 1'b0},
    '{"\\\\srv\\\\x", 0, 1'b0, 0, 1'b0},
    '{"\\\\srv\\sh", 0, 1'b0, 0, 1'b0},
    '{"\\\\#%$\\%\\x", 0, 1'b0, 0, 1'b0},
    '{"\\\\?\\UNC\\srv\\sh\\t", 0, 1'b0, 0, 1'b0},
    '{"\\\\?\\uNc\\s", 0, 1'b0, 0, 1'b0},
    '{"\\\\?\\D:", 0, 1'b1, 6, 1'b0},
    '{"\\\\?\\u:\\x", 0, 1'b1, 7, 1'b0},
    '{"\\\\?\\Volume{01234567-89ab-CDEF-0123-456789abcdef}", 0, 1'b1, 48, 1'b0},
    '{"\\\\?\\vOLUME{FFFFFFFF-0000-aaaa-9999-000000000000}\\x", 0, 1'b1, 49, 1'b0},
    '{"\\\\?\\Volume{0123456-89ab-cdef-0123-456789abcdef}", 0, 1'b1, 0, 1'b1},
    '{"\\\\?x", 0, 1'b1, 0, 1'b1},
    '{"\\\\?\\Vol", 0, 1'b1, 0, 1'b1},
    '{"\\\\", 40, 1'b1, 42, 1'b0}
  };

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [15:0] in_code_unit = 16'h0000;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [14:0] out_root_length;
  logic        out_invalid;

  root_result_t expected_roots [$];
  logic [15:0]  path_units [$];

  prlp_pkg::phase_t cur_phase;
  logic [14:0]      cur_pos;
  logic [15:0]      root_stop;
  logic             share_empty;
  logic [2:0]       guid_group;
  logic [3:0]       unit_count;
  logic             too_long;

  bit          calm = 1'b0;
  int unsigned idle_pct = 0;
  int          fail_count = 0;
  int          results_checked = 0;
  int          units_sent = 0;
  int          rnd_units = 0;
  int          paths_sent = 0;
  int          idle_cycles = 0;

  path_root_length_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_unit    (in_code_unit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_root_length (out_root_length),
    .out_invalid     (out_invalid)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [15:0] upcase(input logic [15:0] cu);
    return (cu >= "a" && cu <= "z") ? cu - 16'd32 : cu;
  endfunction

  function automatic bit is_letter(input logic [15:0] cu);
    return upcase(cu) >= "A" && upcase(cu) <= "Z";
  endfunction

  function automatic bit is_hex(input logic [15:0] cu);
    return (cu >= "0" && cu <= "9") || (upcase(cu) >= "A" && upcase(cu) <= "F");
  endfunction

  function automatic void clear_root_state();
    cur_phase   = prlp_pkg::PH_START;
    cur_pos     = '0;
    root_stop   = '0;
    share_empty = 1'b1;
    guid_group  = '0;
    unit_count  = '0;
    too_long    = 1'b0;
  endfunction

  function automatic void root_settle(input logic [15:0] stop);
    root_stop = stop;
    cur_phase = prlp_pkg::PH_DONE;
  endfunction

  function automatic void root_reject();
    root_stop = '0;
    cur_phase = prlp_pkg::PH_BAD;
  endfunction

  function automatic void server_step(input logic [15:0] cu);
    if (cu == U_SEP) begin
      share_empty = 1'b1;
      cur_phase = prlp_pkg::PH_SHARE;
    end else begin
      cur_phase = prlp_pkg::PH_SERVER;
    end
  endfunction

  // Advances the expected parser state by one code unit; returns 1 when a result is due.
  function automatic bit root_step(input logic [15:0] cu, output root_result_t res);
    logic [15:0] up;
    int          r;
    up = upcase(cu);
    res = '0;
    if (cu == U_TERM) begin
      case (cur_phase)
        prlp_pkg::PH_S1:                         r = 1;
        prlp_pkg::PH_DRV2, prlp_pkg::PH_S2:      r = 2;
        prlp_pkg::PH_SERVER, prlp_pkg::PH_SHARE: r = int'(cur_pos);
        prlp_pkg::PH_D6:                         r = 6;
        prlp_pkg::PH_VEND:                       r = 48;
        prlp_pkg::PH_DONE:                       r = int'(root_stop);
        default:                                 r = -1;
      endcase
      if (too_long || r < 0 || r > prlp_pkg::MaxRootLen) res.inv = 1'b1;
      else res.len = 15'(r);
      clear_root_state();
      return 1'b1;
    end
    case (cur_phase)
      prlp_pkg::PH_START: begin
        if (cu == U_SEP) cur_phase = prlp_pkg::PH_S1;
        else if (is_letter(cu)) cur_phase = prlp_pkg::PH_DRV1;
        else root_reject();
      end
      prlp_pkg::PH_S1: begin
        if (cu == U_SEP) cur_phase = prlp_pkg::PH_S2;
        else root_settle(16'd1);
      end
      prlp_pkg::PH_DRV1: begin
        if (cu == U_COLON) cur_phase = prlp_pkg::PH_DRV2;
        else root_reject();
      end
      prlp_pkg::PH_DRV2: root_settle((cu == U_SEP) ? 16'd3 : 16'd2);
      prlp_pkg::PH_S2: begin
        if (cu == U_QUEST) cur_phase = prlp_pkg::PH_Q3;
        else server_step(cu);
      end
      prlp_pkg::PH_SERVER: server_step(cu);
      prlp_pkg::PH_SHARE: begin
        if (share_empty) begin
          if (cu == U_SEP) root_settle({1'b0, cur_pos});
          else share_empty = 1'b0;
        end else if (cu == U_SEP) begin
          root_settle({1'b0, cur_pos} + 16'd1);
        end
      end
      prlp_pkg::PH_Q3: begin
        if (cu == U_SEP) cur_phase = prlp_pkg::PH_X4;
        else root_reject();
      end
      prlp_pkg::PH_X4: begin
        if (up == "U") cur_phase = prlp_pkg::PH_U5;
        else if (up == "V") cur_phase = prlp_pkg::PH_V5;
        else if (is_letter(cu)) cur_phase = prlp_pkg::PH_D5;
        else root_reject();
      end
      prlp_pkg::PH_D5: begin
        if (cu == U_COLON) cur_phase = prlp_pkg::PH_D6;
        else root_reject();
      end
      prlp_pkg::PH_D6: root_settle((cu == U_SEP) ? 16'd7 : 16'd6);
      prlp_pkg::PH_U5: begin
        if (cu == U_COLON) cur_phase = prlp_pkg::PH_D6;
        else if (up == "N") cur_phase = prlp_pkg::PH_U6;
        else root_reject();
      end
      prlp_pkg::PH_U6: begin
        if (up == "C") cur_phase = prlp_pkg::PH_U7;
        else root_reject();
      end
      prlp_pkg::PH_U7: begin
        if (cu == U_SEP) cur_phase = prlp_pkg::PH_SERVER;
        else root_reject();
      end
      prlp_pkg::PH_V5: begin
        if (cu == U_COLON) begin
          cur_phase = prlp_pkg::PH_D6;
        end else if (up == "O") begin
          unit_count = 4'd2;
          cur_phase = prlp_pkg::PH_VPREFIX;
        end else begin
          root_reject();
        end
      end
      prlp_pkg::PH_VPREFIX: begin
        if (unit_count < 4'd7 && up == {8'h00, VOL_WORD[8 * (6 - int'(unit_count)) +: 8]}) begin
          unit_count++;
          if (unit_count == 4'd7) begin
            unit_count = '0;
            guid_group = '0;
            cur_phase = prlp_pkg::PH_HEX;
          end
        end else begin
          root_reject();
        end
      end
      prlp_pkg::PH_HEX: begin
        if (is_hex(cu) && guid_group < 3'd5) begin
          unit_count++;
          if (unit_count >= GUID_GROUP_LEN[4 * (4 - int'(guid_group)) +: 4])
            cur_phase = (guid_group < 3'd4) ? prlp_pkg::PH_DASH : prlp_pkg::PH_CLOSE;
        end else begin
          root_reject();
        end
      end
      prlp_pkg::PH_DASH: begin
        if (cu == U_DASH) begin
          guid_group++;
          unit_count = '0;
          cur_phase = prlp_pkg::PH_HEX;
        end else begin
          root_reject();
        end
      end
      prlp_pkg::PH_CLOSE: begin
        if (cu == U_CLOSE) cur_phase = prlp_pkg::PH_VEND;
        else root_reject();
      end
      prlp_pkg::PH_VEND: root_settle((cu == U_SEP) ? 16'd49 : 16'd48);
      prlp_pkg::PH_DONE: ;
      default: root_reject();
    endcase
    if (cur_pos >= 15'(prlp_pkg::MaxPathUnits)) too_long = 1'b1;
    else cur_pos++;
    return 1'b0;
  endfunction

  function automatic logic [15:0] text_unit(input byte ch);
    case (ch)
      "#":     return 16'hFFFF;
      "$":     return 16'h0141;
      "%":     return 16'h015C;
      default: return {8'h00, ch};
    endcase
  endfunction

  function automatic logic [15:0] rnd_letter();
    return 16'("A" + $urandom_range(0, 25)) | ($urandom_range(0, 1) ? 16'h0020 : 16'h0000);
  endfunction

  function automatic logic [15:0] rnd_hex();
    int unsigned n;
    n = $urandom_range(0, 15);
    if (n < 10) return 16'("0" + n);
    return 16'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [15:0] any_unit();
    case ($urandom_range(0, 9))
      0, 1: return U_SEP;
      2: begin
        case ($urandom_range(0, 4))
          0:       return U_COLON;
          1:       return U_QUEST;
          2:       return U_DASH;
          3:       return U_OPEN;
          default: return U_CLOSE;
        endcase
      end
      3, 4:    return rnd_letter();
      5:       return rnd_hex();
      6:       return 16'h0100 | 16'($urandom_range(0, 255));
      7:       return 16'($urandom_range(1, 65535));
      8:       return 16'($urandom_range(1, 127));
      default: return 16'hFFFF ^ (16'h0001 << $urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [15:0] plain_unit();
    logic [15:0] cu;
    do cu = any_unit(); while (cu == U_SEP);
    return cu;
  endfunction

  function automatic void put_word(input string s);
    logic [15:0] cu;
    for (int i = 0; i < s.len(); i++) begin
      cu = {8'h00, s[i]};
      if (is_letter(cu) && $urandom_range(0, 1)) cu ^= 16'h0020;
      path_units.push_back(cu);
    end
  endfunction

  function automatic void put_tail();
    repeat ($urandom_range(0, 5)) path_units.push_back(any_unit());
  endfunction

  function automatic void put_walk();
    repeat ($urandom_range(0, 4)) path_units.push_back(plain_unit());
    if ($urandom_range(0, 3) != 0) begin
      path_units.push_back(U_SEP);
      repeat ($urandom_range(0, 4)) path_units.push_back(plain_unit());
      if ($urandom_range(0, 1)) path_units.push_back(U_SEP);
      put_tail();
    end
  endfunction

  function automatic void put_long_prefix();
    path_units.push_back(U_SEP);
    path_units.push_back(U_SEP);
    path_units.push_back(U_QUEST);
    path_units.push_back(U_SEP);
  endfunction

  function automatic void build_random_path();
    int unsigned kind;
    path_units.delete();
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        path_units.push_back(rnd_letter());
        path_units.push_back(U_COLON);
        if ($urandom_range(0, 1)) path_units.push_back(U_SEP);
        put_tail();
      end
      1: begin
        path_units.push_back(U_SEP);
        if ($urandom_range(0, 3) != 0) begin
          path_units.push_back(plain_unit());
          put_tail();
        end
      end
      2, 3: begin
        path_units.push_back(U_SEP);
        path_units.push_back(U_SEP);
        put_walk();
      end
      4: begin
        put_long_prefix();
        put_word("UNC");
        path_units.push_back(U_SEP);
        put_walk();
      end
      5: begin
        put_long_prefix();
        case ($urandom_range(0, 2))
          0:       put_word("U");
          1:       put_word("V");
          default: path_units.push_back(rnd_letter());
        endcase
        path_units.push_back(U_COLON);
        if ($urandom_range(0, 1)) path_units.push_back(U_SEP);
        put_tail();
      end
      8: begin
        repeat ($urandom_range(0, 12)) path_units.push_back(any_unit());
      end
      default: begin
        put_long_prefix();
        put_word("Volume{");
        for (int g = 0; g < 5; g++) begin
          if (g > 0) path_units.push_back(U_DASH);
          repeat (GUID_GROUP_LEN[4 * (4 - g) +: 4]) path_units.push_back(rnd_hex());
        end
        path_units.push_back(U_CLOSE);
        if ($urandom_range(0, 1)) path_units.push_back(U_SEP);
        put_tail();
      end
    endcase
    if (path_units.size() > 0 && $urandom_range(0, 5) == 0)
      path_units[$urandom_range(0, path_units.size() - 1)] = any_unit();
    if (kind == 9 && path_units.size() > 0)
      repeat ($urandom_range(1, path_units.size())) void'(path_units.pop_back());
  endfunction

  task automatic send_unit(input logic [15:0] cu, input bit typed, input root_result_t want);
    root_result_t predicted;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_code_unit <= cu;
    do @(posedge clk); while (!in_ready);
    if (root_step(cu, predicted)) begin
      expected_roots.push_back(typed ? want : predicted);
      paths_sent++;
    end
    units_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    root_result_t want;
    int           rnd_paths;
    rnd_paths = 0;
    clear_root_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_cases[i]) begin
      idle_pct = (dir_cases[i].pad > 0) ? 0 : 25;
      want.len = 15'(dir_cases[i].want_len);
      want.inv = dir_cases[i].want_inv;
      for (int k = 0; k < dir_cases[i].head.len(); k++)
        send_unit(text_unit(dir_cases[i].head[k]), 1'b0, '0);
      repeat (dir_cases[i].pad) send_unit(U_PAD, 1'b0, '0);
      send_unit(U_TERM, dir_cases[i].typed, want);
    end
    drain_results();

    while (rnd_units < RANDOM_UNITS || rnd_paths < MIN_RND_PATHS) begin
      if (rnd_paths == 40) drain_results();
      if (rnd_units >= CALM_UNITS) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      build_random_path();
      foreach (path_units[k]) send_unit(path_units[k], 1'b0, '0);
      send_unit(U_TERM, 1'b0, '0);
      rnd_units += path_units.size() + 1;
      rnd_paths++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d paths in %0d code units (%0d random units); %0d results checked.",
             paths_sent, units_sent, rnd_units, results_checked);
    $display("Covered separator, drive, UNC and extended forms, long server names and noise.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : ready_driver
    int unsigned stall_pct;
    stall_pct = 10;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_roots.size() == 0) begin
        $error("unexpected result word: root_length %0d, invalid %0d",
               out_root_length, out_invalid);
        fail_count++;
      end else begin
        want = expected_roots.pop_front();
        if (out_root_length !== want.len) begin
          $error("root_length mismatch: expected %0d, actual %0d", want.len, out_root_length);
          fail_count++;
        end
        if (out_invalid !== want.inv) begin
          $error("invalid mismatch: expected %0d, actual %0d", want.inv, out_invalid);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
